>>> design/tsag_pkg.sv
// Types and constants shared by the tempo-synced audio gate.
package tsag_pkg;

	localparam int PERIOD_W    = 20;
	localparam int FADE_W      = 16;
	localparam int DEPTH_W     = 17;
	localparam int GAIN_W      = 17;
	localparam int QUOT_W      = 17;
	localparam int PROD_W      = DEPTH_W + FADE_W;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 20;
	localparam int REGION_W    = 2;

	localparam logic [GAIN_W-1:0]   GAIN_ONE     = 17'h10000;
	localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 20'd2;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd5513;
	localparam logic [FADE_W-1:0]   FADE_MIN     = 16'd1;
	localparam logic [FADE_W-1:0]   FADE_RESET   = 16'd88;
	localparam logic [DEPTH_W-1:0]  DEPTH_RESET  = 17'd0;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_PERIOD = 2'd0;
	localparam cfg_index_t REG_FADE   = 2'd1;
	localparam cfg_index_t REG_DEPTH  = 2'd2;

	typedef enum logic [REGION_W-1:0] {
		REGION_RAMP_UP,
		REGION_OPEN,
		REGION_RAMP_DOWN,
		REGION_CLOSED
	} region_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [PERIOD_W-1:0] half;
		logic [FADE_W-1:0]   fade;
		logic [PERIOD_W-1:0] fade_end;
		logic [DEPTH_W-1:0]  depth;
		logic [GAIN_W-1:0]   off;
	} gate_cfg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCALE,
		BK_DIVIDE,
		BK_GAIN,
		BK_MULTIPLY,
		BK_DELIVER
	} back_state_t;

endpackage

>>> design/tsag_if.sv
// Handshake interfaces for the sample, result and register write channels.
interface tsag_in_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_left;
	logic signed [SAMPLE_BITS-1:0] sample_right;

	modport source (output valid, output sample_left, output sample_right, input ready);
	modport sink (input valid, input sample_left, input sample_right, output ready);
endinterface

interface tsag_out_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] gated_left;
	logic signed [SAMPLE_BITS-1:0] gated_right;

	modport source (output valid, output gated_left, output gated_right, input ready);
	modport sink (input valid, input gated_left, input gated_right, output ready);
endinterface

interface tsag_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [19:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/tsag_fifo.sv
// Small register queue between the classifying front and the gain back end.
module tsag_fifo #(
	parameter int WIDTH = 66,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> design/tsag_front.sv
// Front end: accepts sample items, tracks the gate phase and classifies the gain region.
module tsag_front
	import tsag_pkg::*;
#(
	parameter int SAMPLE_BITS = 24,
	parameter int PHASE_BITS  = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tsag_in_if.sink                         samples,
	input  gate_cfg_t                       cfg,
	input  logic                            restart,
	output logic                            push_valid,
	input  logic                            push_ready,
	output logic [2*SAMPLE_BITS+REGION_W+FADE_W-1:0] push_data
);

	localparam int CW = (PHASE_BITS > PERIOD_W) ? PHASE_BITS : PERIOD_W;

	logic [PHASE_BITS-1:0] phase_q;
	logic [CW-1:0]         phase_ext;
	logic [CW-1:0]         phase_eff;
	logic [CW-1:0]         period_ext;
	logic [CW-1:0]         half_ext;
	logic [CW-1:0]         fade_ext;
	logic [CW-1:0]         fade_end_ext;
	logic [CW-1:0]         down_off;
	logic [CW:0]           phase_inc;
	logic [PHASE_BITS-1:0] phase_next;
	region_t               region;
	logic [FADE_W-1:0]     ramp_pos;
	logic                  accept;

	assign phase_ext    = CW'(phase_q);
	assign period_ext   = CW'(cfg.period);
	assign half_ext     = CW'(cfg.half);
	assign fade_ext     = CW'(cfg.fade);
	assign fade_end_ext = CW'(cfg.fade_end);
	assign phase_eff    = (phase_ext >= period_ext) ? '0 : phase_ext;
	assign down_off     = phase_eff - half_ext;
	assign phase_inc    = {1'b0, phase_eff} + 1'b1;
	assign phase_next   = (phase_inc >= {1'b0, period_ext}) ? '0 : phase_inc[PHASE_BITS-1:0];

	always_comb begin
		if (phase_eff < fade_ext) begin
			region = REGION_RAMP_UP;
		end else if (phase_eff < half_ext) begin
			region = REGION_OPEN;
		end else if (phase_eff < fade_end_ext) begin
			region = REGION_RAMP_DOWN;
		end else begin
			region = REGION_CLOSED;
		end
	end

	assign ramp_pos = (region == REGION_RAMP_UP) ? phase_eff[FADE_W-1:0] : down_off[FADE_W-1:0];

	assign samples.ready = push_ready;
	assign push_valid    = samples.valid;
	assign push_data     = {samples.sample_left, samples.sample_right, region, ramp_pos};
	assign accept        = samples.valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (restart) begin
			phase_q <= '0;
		end else if (accept) begin
			phase_q <= phase_next;
		end
	end

endmodule

>>> design/tsag_back.sv
// Back end: works out the gate gain, on the fade ramps with a serial divider, and scales both channels.
module tsag_back
	import tsag_pkg::*;
#(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  gate_cfg_t                                 cfg,
	input  logic                                      pop_valid,
	output logic                                      pop_ready,
	input  logic [2*SAMPLE_BITS+REGION_W+FADE_W-1:0] pop_data,
	tsag_out_if.source                                gated
);

	localparam int EW = 2 * SAMPLE_BITS + REGION_W + FADE_W;
	localparam int PW = SAMPLE_BITS + GAIN_W + 1;
	localparam int CNT_W = $clog2(QUOT_W);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUOT_W - 1);
	localparam logic signed [PW-1:0] ROUND_HALF = PW'(32768);

	back_state_t                    state_q;
	back_state_t                    state_d;
	logic signed [SAMPLE_BITS-1:0]  left_q;
	logic signed [SAMPLE_BITS-1:0]  right_q;
	region_t                        region_q;
	logic [FADE_W-1:0]              pos_q;
	logic [FADE_W-1:0]              rem_q;
	logic [QUOT_W-1:0]              dq_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [GAIN_W-1:0]              gain_q;
	logic signed [PW-1:0]           prod_l_q;
	logic signed [PW-1:0]           prod_r_q;
	logic signed [SAMPLE_BITS-1:0]  out_l_q;
	logic signed [SAMPLE_BITS-1:0]  out_r_q;
	logic                           out_valid_q;
	logic [PROD_W-1:0]              scaled;
	logic [FADE_W:0]                trial;
	logic [FADE_W:0]                trial_diff;
	logic                           trial_ge;
	logic signed [PW-1:0]           rnd_l;
	logic signed [PW-1:0]           rnd_r;
	logic                           load_out;
	logic                           is_ramp;

	function automatic logic [SAMPLE_BITS-1:0] saturate(input logic [SAMPLE_BITS+1:0] v);
		logic [2:0] top;
		top = v[SAMPLE_BITS+1:SAMPLE_BITS-1];
		if (top == 3'b000 || top == 3'b111) begin
			return v[SAMPLE_BITS-1:0];
		end else if (v[SAMPLE_BITS+1]) begin
			return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	endfunction

	assign scaled     = PROD_W'(cfg.depth) * PROD_W'(pos_q);
	assign trial      = {rem_q, dq_q[QUOT_W-1]};
	assign trial_diff = trial - {1'b0, cfg.fade};
	assign trial_ge   = (trial >= {1'b0, cfg.fade});
	assign rnd_l      = prod_l_q + ROUND_HALF;
	assign rnd_r      = prod_r_q + ROUND_HALF;
	assign load_out   = (state_q == BK_DELIVER) && (!out_valid_q || gated.ready);
	assign is_ramp    = (region_q == REGION_RAMP_UP) || (region_q == REGION_RAMP_DOWN);

	assign gated.valid       = out_valid_q;
	assign gated.gated_left  = out_l_q;
	assign gated.gated_right = out_r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_d = BK_SCALE;
				end
			end
			BK_SCALE: begin
				state_d = is_ramp ? BK_DIVIDE : BK_MULTIPLY;
			end
			BK_DIVIDE: begin
				if (cnt_q == DIV_LAST) begin
					state_d = BK_GAIN;
				end
			end
			BK_GAIN: begin
				state_d = BK_MULTIPLY;
			end
			BK_MULTIPLY: begin
				state_d = BK_DELIVER;
			end
			BK_DELIVER: begin
				if (load_out) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == BK_DIVIDE) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (gated.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && pop_valid) begin
			left_q   <= pop_data[EW-1 -: SAMPLE_BITS];
			right_q  <= pop_data[EW-1-SAMPLE_BITS -: SAMPLE_BITS];
			region_q <= region_t'(pop_data[FADE_W+REGION_W-1:FADE_W]);
			pos_q    <= pop_data[FADE_W-1:0];
		end
		if (state_q == BK_SCALE) begin
			rem_q <= scaled[PROD_W-1:QUOT_W];
			dq_q  <= scaled[QUOT_W-1:0];
			case (region_q)
				REGION_OPEN: begin
					gain_q <= GAIN_ONE;
				end
				REGION_CLOSED: begin
					gain_q <= cfg.off;
				end
				default: begin
					gain_q <= gain_q;
				end
			endcase
		end
		if (state_q == BK_DIVIDE) begin
			rem_q <= trial_ge ? trial_diff[FADE_W-1:0] : trial[FADE_W-1:0];
			dq_q  <= {dq_q[QUOT_W-2:0], trial_ge};
		end
		if (state_q == BK_GAIN) begin
			if (region_q == REGION_RAMP_UP) begin
				gain_q <= cfg.off + dq_q;
			end else begin
				gain_q <= GAIN_ONE - dq_q;
			end
		end
		if (state_q == BK_MULTIPLY) begin
			prod_l_q <= PW'(left_q) * PW'($signed({1'b0, gain_q}));
			prod_r_q <= PW'(right_q) * PW'($signed({1'b0, gain_q}));
		end
		if (load_out) begin
			out_l_q <= saturate(rnd_l[PW-1:16]);
			out_r_q <= saturate(rnd_r[PW-1:16]);
		end
	end

`ifndef NO_ASSERTIONS
	a_gain_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MULTIPLY) |-> (gain_q <= GAIN_ONE))
		else $error("gate gain above unity");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIVIDE) |-> ({1'b0, rem_q} < {1'b0, cfg.fade}))
		else $error("divider remainder not below the fade length");

	a_pop_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |=> (state_q == BK_SCALE))
		else $error("item taken from the queue without starting work");

	a_divide_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIVIDE && cnt_q == DIV_LAST) |=> (state_q == BK_GAIN))
		else $error("divider ran past its last step");
`endif

endmodule

>>> design/tempo_synced_audio_gate_top.sv
// Top level of the tempo-synced stereo audio gate.
//
// Channel   Direction  Carries
// cfg       in         register index and write data, always ready
// samples   in         sample_left, sample_right
// gated     out        gated_left, gated_right
//
// An item in the open or closed half passes through the scale, multiply and deliver states of
// the back end; an item on a fade ramp also passes through the 17-step serial divider and the gain state.
// The front end hands an item on to the queue whenever the queue has room.
// The result register lets the next item start while a result waits to be taken.
// Reset restores the register defaults and clears the phase; writing the period also
// restarts the phase.
module tempo_synced_audio_gate_top
	import tsag_pkg::*;
#(
	parameter int SAMPLE_BITS = 24,
	parameter int PHASE_BITS  = 20,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	tsag_cfg_if.sink   cfg,
	tsag_in_if.sink    samples,
	tsag_out_if.source gated
);

	localparam int EW = 2 * SAMPLE_BITS + REGION_W + FADE_W;

	logic [PERIOD_W-1:0] period_q;
	logic [FADE_W-1:0]   fade_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic [PERIOD_W-1:0] period_eff;
	logic [PERIOD_W-1:0] half;
	logic [FADE_W-1:0]   fade_min;
	logic [FADE_W-1:0]   fade_eff;
	logic [DEPTH_W-1:0]  depth_eff;
	gate_cfg_t           gate_cfg;
	logic                cfg_write;
	logic                restart;
	logic                push_valid;
	logic                push_ready;
	logic [EW-1:0]       push_data;
	logic                pop_valid;
	logic                pop_ready;
	logic [EW-1:0]       pop_data;

	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid && cfg.ready;
	assign restart   = cfg_write && (cfg.index == REG_PERIOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			fade_q   <= FADE_RESET;
			depth_q  <= DEPTH_RESET;
		end else if (cfg_write) begin
			case (cfg.index)
				REG_PERIOD: begin
					period_q <= cfg.data[PERIOD_W-1:0];
				end
				REG_FADE: begin
					fade_q <= cfg.data[FADE_W-1:0];
				end
				REG_DEPTH: begin
					depth_q <= cfg.data[DEPTH_W-1:0];
				end
				default: begin
					period_q <= period_q;
				end
			endcase
		end
	end

	assign period_eff = (period_q < PERIOD_MIN) ? PERIOD_MIN : period_q;
	assign half       = {1'b0, period_eff[PERIOD_W-1:1]};
	assign fade_min   = (fade_q < FADE_MIN) ? FADE_MIN : fade_q;
	assign fade_eff   = (PERIOD_W'(fade_min) > half) ? half[FADE_W-1:0] : fade_min;
	assign depth_eff  = (depth_q > GAIN_ONE) ? GAIN_ONE : depth_q;

	assign gate_cfg.period   = period_eff;
	assign gate_cfg.half     = half;
	assign gate_cfg.fade     = fade_eff;
	assign gate_cfg.fade_end = half + PERIOD_W'(fade_eff);
	assign gate_cfg.depth    = depth_eff;
	assign gate_cfg.off      = GAIN_ONE - depth_eff;

	tsag_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.PHASE_BITS  (PHASE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.cfg        (gate_cfg),
		.restart    (restart),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	tsag_fifo #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	tsag_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (gate_cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.gated     (gated)
	);

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the tempo-synced stereo audio gate with its own gain predictor.
module testbench;
	import tsag_pkg::*;

	localparam int SAMPLE_BITS  = 24;
	localparam int RANDOM_ITEMS = 1350;
	localparam int CYCLE_LIMIT  = 400000;

	localparam cfg_index_t REG_SPARE = 2'd3;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	class gate_scoreboard;
		logic [PERIOD_W-1:0] period_reg;
		logic [FADE_W-1:0]   fade_reg;
		logic [DEPTH_W-1:0]  depth_reg;
		logic [PERIOD_W-1:0] phase;
		sample_t             want_left[$];
		sample_t             want_right[$];
		int                  errors;

		function new();
			period_reg = PERIOD_RESET;
			fade_reg   = FADE_RESET;
			depth_reg  = DEPTH_RESET;
			phase      = '0;
			errors     = 0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PERIOD: begin
					period_reg = data[PERIOD_W-1:0];
					phase      = '0;
				end
				REG_FADE:  fade_reg = data[FADE_W-1:0];
				REG_DEPTH: depth_reg = data[DEPTH_W-1:0];
				default: ;
			endcase
		endfunction

		// Works out the gain for the current phase and steps the phase on by one.
		function logic [GAIN_W-1:0] gate_gain();
			logic [PERIOD_W-1:0] period;
			logic [PERIOD_W-1:0] half;
			logic [PERIOD_W-1:0] fade;
			logic [PERIOD_W-1:0] ph;
			logic [GAIN_W-1:0]   depth;
			logic [GAIN_W-1:0]   off;
			logic [GAIN_W-1:0]   quot;
			region_t             region;
			period = (period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg;
			half   = period >> 1;
			fade   = fade_reg;
			if (fade < FADE_MIN)
				fade = FADE_MIN;
			if (fade > half)
				fade = half;
			depth = (depth_reg > GAIN_ONE) ? GAIN_ONE : depth_reg;
			off   = GAIN_ONE - depth;
			ph    = (phase >= period) ? '0 : phase;
			if (ph < fade)
				region = REGION_RAMP_UP;
			else if (ph < half)
				region = REGION_OPEN;
			else if (ph < half + fade)
				region = REGION_RAMP_DOWN;
			else
				region = REGION_CLOSED;
			phase = (ph + 1 >= period) ? '0 : ph + 1'b1;
			case (region)
				REGION_RAMP_UP: begin
					quot = GAIN_W'((64'(depth) * 64'(ph)) / 64'(fade));
					return off + quot;
				end
				REGION_OPEN: return GAIN_ONE;
				REGION_RAMP_DOWN: begin
					quot = GAIN_W'((64'(depth) * 64'(ph - half)) / 64'(fade));
					return GAIN_ONE - quot;
				end
				default: return off;
			endcase
		endfunction

		function sample_t scale(sample_t s, logic [GAIN_W-1:0] gain);
			longint g;
			longint p;
			g = gain;
			p = (longint'(s) * g + 32768) >>> 16;
			if (p > longint'(SAMPLE_MAX))
				p = SAMPLE_MAX;
			if (p < longint'(SAMPLE_MIN))
				p = SAMPLE_MIN;
			return sample_t'(p);
		endfunction

		function void note_pair(sample_t left, sample_t right);
			logic [GAIN_W-1:0] gain;
			gain = gate_gain();
			want_left.push_back(scale(left, gain));
			want_right.push_back(scale(right, gain));
		endfunction

		function void check_pair(sample_t left, sample_t right);
			sample_t el;
			sample_t er;
			if (want_left.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, expected none, got %0d / %0d",
					$time, left, right);
				return;
			end
			el = want_left.pop_front();
			er = want_right.pop_front();
			if (left !== el) begin
				errors++;
				$display("%0t: gated_left expected %0d, got %0d", $time, el, left);
			end
			if (right !== er) begin
				errors++;
				$display("%0t: gated_right expected %0d, got %0d", $time, er, right);
			end
		endfunction

		function int pending();
			return want_left.size();
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   calm   = 1'b0;
	int   cycles = 0;
	int   sent   = 0;

	gate_scoreboard sb = new();

	tsag_cfg_if                              cfg();
	tsag_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) samples();
	tsag_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) gated();

	tempo_synced_audio_gate_top #(.SAMPLE_BITS(SAMPLE_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.samples(samples),
		.gated(gated)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end else if (arst_n) begin
			if (cfg.valid && cfg.ready)
				sb.write_reg(cfg.index, cfg.data);
			if (samples.valid && samples.ready)
				sb.note_pair(samples.sample_left, samples.sample_right);
			if (gated.valid && gated.ready)
				sb.check_pair(gated.gated_left, gated.gated_right);
		end
	end

	always @(posedge clk) begin
		gated.ready <= calm || ($urandom_range(99) >= 19);
	end

	task automatic push_pair(input sample_t left, input sample_t right);
		while (!calm && $urandom_range(99) < 19) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid        <= 1'b1;
		samples.sample_left  <= left;
		samples.sample_right <= right;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		sent++;
	endtask

	// Leaves valid high so that back-to-back writes need no gap; end_writes lowers it.
	task automatic program_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
	endtask

	task automatic end_writes();
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: return sample_t'($urandom_range(16) - 8);
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic random_settings();
		logic [CFG_DATA_W-1:0] data;
		int                    pick;
		if ($urandom_range(9) < 8) begin
			pick = $urandom_range(99);
			if (pick < 4)
				data = CFG_DATA_W'($urandom_range(1));
			else if (pick < 10)
				data = CFG_DATA_W'($urandom);
			else
				data = CFG_DATA_W'($urandom_range(70, 2));
			program_reg(REG_PERIOD, data);
		end
		if ($urandom_range(9) < 7) begin
			pick = $urandom_range(99);
			if (pick < 10)
				data = CFG_DATA_W'($urandom);
			else if (pick < 15)
				data = 20'h0FFFF;
			else
				data = CFG_DATA_W'($urandom_range(40));
			program_reg(REG_FADE, data);
		end
		if ($urandom_range(9) < 7) begin
			pick = $urandom_range(99);
			data = CFG_DATA_W'($urandom);
			if (pick < 15)
				data[DEPTH_W-1:0] = '0;
			else if (pick < 30)
				data[DEPTH_W-1:0] = GAIN_ONE;
			else if (pick >= 40)
				data[DEPTH_W-1:0] = DEPTH_W'($urandom_range(65536));
			program_reg(REG_DEPTH, data);
		end
		if ($urandom_range(19) == 0)
			program_reg(REG_SPARE, CFG_DATA_W'($urandom));
		end_writes();
	endtask

	initial begin
		int n;
		cfg.valid            = 1'b0;
		cfg.index            = REG_PERIOD;
		cfg.data             = '0;
		samples.valid        = 1'b0;
		samples.sample_left  = '0;
		samples.sample_right = '0;
		gated.ready          = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults give zero depth, so the samples pass unchanged.
		push_pair(SAMPLE_MAX, SAMPLE_MIN);
		push_pair(SAMPLE_MIN, SAMPLE_MAX);
		push_pair('0, -1);
		wait_drained();

		// Short period, zero fade and excess depth, after a write to an unused index.
		program_reg(REG_SPARE, 20'hFFFFF);
		program_reg(REG_PERIOD, 20'd0);
		program_reg(REG_FADE, 20'd0);
		program_reg(REG_DEPTH, 20'h1FFFF);
		end_writes();
		repeat (2) begin
			push_pair(SAMPLE_MAX, SAMPLE_MIN);
			push_pair(SAMPLE_MIN, SAMPLE_MAX);
		end
		wait_drained();

		// Half depth on the shortest period, with rounding ties on small samples.
		program_reg(REG_PERIOD, 20'd1);
		program_reg(REG_FADE, 20'hFFFFF);
		program_reg(REG_DEPTH, 20'd32768);
		end_writes();
		push_pair(1, -1);
		push_pair(3, -3);
		push_pair(1, -1);
		push_pair(3, -3);
		wait_drained();

		// Longest period with the longest fade.
		program_reg(REG_PERIOD, 20'hFFFFF);
		program_reg(REG_FADE, 20'h0FFFF);
		program_reg(REG_DEPTH, 20'h10000);
		end_writes();
		push_pair(SAMPLE_MAX, SAMPLE_MIN);
		push_pair(SAMPLE_MIN, SAMPLE_MAX);
		push_pair(SAMPLE_MAX, SAMPLE_MIN);
		wait_drained();

		// One full period through every region of the gate.
		program_reg(REG_PERIOD, 20'd10);
		program_reg(REG_FADE, 20'd3);
		program_reg(REG_DEPTH, 20'hFFFFF);
		end_writes();
		repeat (5) begin
			push_pair(SAMPLE_MAX, SAMPLE_MIN);
			push_pair(sample_t'(24'h400000), sample_t'(-24'sd4194305));
		end

		for (int ph = 0; sent < 25 + RANDOM_ITEMS; ph++) begin
			wait_drained();
			random_settings();
			calm = (ph == 4);
			n = calm ? 200 : $urandom_range(60, 10);
			for (int i = 0; i < n; i++)
				push_pair(pick_sample(), pick_sample());
		end

		wait_drained();
		calm = 1'b0;
		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
